// ===== design/sets_pkg.sv =====
// ----------------------------------------------------------------------------
// sets_pkg: shared types and constants for the sparse eligibility trace store
// Item kinds, walk operations, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package sets_pkg;

    localparam int FEATURES_DEF   = 4096;
    localparam int MAX_ACTIVE_DEF = 1024;

    localparam logic [15:0] STEP_SIZE_RST = 16'd4096;
    localparam logic [15:0] MIN_START_RST = 16'd66;
    localparam logic [15:0] MIN_TOP       = 16'd65535;
    localparam logic [16:0] TRACE_ONE     = 17'd65536;
    // floor(x / 10) == (x * RECIP10) >> 19 for all 16-bit x
    localparam logic [17:0] RECIP10       = 18'd52429;

    localparam logic REG_STEP_SIZE       = 1'b0;
    localparam logic REG_MIN_TRACE_START = 1'b1;

    typedef enum logic [2:0] {
        KIND_SET      = 3'd0,
        KIND_CLEAR    = 3'd1,
        KIND_DECAY    = 3'd2,
        KIND_UPDATE   = 3'd3,
        KIND_READ     = 3'd4,
        KIND_CLEARALL = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        WOP_CULL,
        WOP_DECAY,
        WOP_UPDATE,
        WOP_CLEARALL
    } walk_op_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_ST1,
        S_ST2,
        S_SL,
        S_RS1,
        S_RS2,
        S_CL1,
        S_CL2,
        S_CL3,
        S_UP1,
        S_UP2,
        S_WK_A,
        S_WK_B,
        S_WK_C,
        S_WK_D,
        S_WK_U1,
        S_WK_U2,
        S_WK_U3,
        S_DROP,
        S_FIN
    } state_t;

endpackage

// ===== design/sparse_eligibility_trace_store.sv =====
// ----------------------------------------------------------------------------
// sparse_eligibility_trace_store: trace and weight store for linear Sarsa(lambda)
// Per-feature traces and weights, a compact active list, rising minimum trace.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one command transaction; s_tuser = kind (set, clear, decay,
//   update weights, read weight, clear all), s_tdata = feature, trace or
//   rate, TD error. m_ channel: one result transaction per command with the
//   weight read (else 0), the active count and the current minimum trace.
//   APB port: step_size at 0x0, min_trace_start at 0x4.
// Sequencing (one command at a time, s_tready low while it runs)
//   read weight, clear and set with room need no walk; unused kinds go
//   straight to the result. Decay, update weights and clear all each walk
//   the active list. A set on a full list raises the minimum and culls the
//   list until a slot frees or the minimum reaches its top, so it can take
//   several walks. All walks visit each listed entry once.
// Reset
//   a clearing pass zeroes every trace and weight with s_tready low;
//   register writes are taken meanwhile.
// Stalls
//   a result waits in the output register; the next command is already
//   accepted, and only its own result waits for the register to free.
// ----------------------------------------------------------------------------
module sparse_eligibility_trace_store
    import sets_pkg::*;
#(
    parameter int FEATURES   = FEATURES_DEF,
    parameter int MAX_ACTIVE = MAX_ACTIVE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // feature[11:0], trace_or_rate[28:12], td_error[60:29]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // weight_value[31:0], active_count[42:32], min_trace_now[58:43]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW = $clog2(FEATURES);
    localparam int PW = $clog2(MAX_ACTIVE);
    localparam int CW = $clog2(MAX_ACTIVE + 1);

    // ---------------- registers ----------------
    state_t         state_reg, state_next;
    walk_op_t       op_reg, op_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [15:0]    min_reg, min_next;
    logic [15:0]    step_reg, min_start_reg;
    logic [FW-1:0]  clr_reg, clr_next;
    logic [FW-1:0]  feat_reg, feat_next;
    logic           ok_reg, ok_next;
    logic [16:0]    val_reg, val_next;
    logic [31:0]    delta_reg, delta_next;
    logic           single_reg, single_next;
    logic [FW-1:0]  ent_reg, ent_next;
    logic [FW-1:0]  last_reg, last_next;
    logic [16:0]    trace_reg, trace_next;
    logic [31:0]    weight_reg, weight_next;
    logic [47:0]    sd_reg, sd_next;
    logic [40:0]    lo_reg, lo_next;
    logic [33:0]    inc_reg, inc_next;
    logic [31:0]    wout_reg, wout_next;
    logic signed [50:0] mul_reg;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [63:0]    m_tdata_reg, m_tdata_next;

    // shared multiplier operands
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;

    // memory ports
    logic             t_we, w_we, l_we, p_we;
    logic [FW-1:0]    t_waddr, t_raddr, w_waddr, w_raddr, p_waddr, p_raddr;
    logic [PW-1:0]    l_waddr, l_raddr;
    logic [16:0]      t_wdata, t_rdata;
    logic [31:0]      w_wdata, w_rdata;
    logic [FW-1:0]    l_wdata, l_rdata;
    logic [PW-1:0]    p_wdata, p_rdata;

    // ---------------- command decode ----------------
    logic        s_fire;
    logic [16:0] in_val;
    logic [16:0] in_val_clip;
    logic        in_ok;

    assign s_fire      = s_tvalid && s_tready;
    assign in_val      = s_tdata[28:12];
    assign in_val_clip = (in_val > TRACE_ONE) ? TRACE_ONE : in_val;
    assign in_ok       = (32'(s_tdata[11:0]) < 32'(FEATURES));
    assign s_tready    = (state_reg == S_IDLE);

    // ---------------- per-entry decisions ----------------
    logic [16:0] decay_new;
    logic        drop_cull, drop_decay;
    logic [15:0] tenth;
    logic [15:0] raise_inc;
    logic [16:0] raise_sum;
    logic signed [65:0] prod;
    logic signed [34:0] wsum;
    logic [31:0]        wsat;
    logic               out_free;

    assign decay_new  = mul_reg[32:16];
    assign drop_cull  = (t_rdata < {1'b0, min_reg});
    assign drop_decay = (decay_new == 17'd0) || (decay_new < {1'b0, min_reg});
    assign tenth      = mul_reg[34:19];
    assign raise_inc  = (tenth == 16'd0) ? 16'd1 : tenth;
    assign raise_sum  = {1'b0, min_reg} + {1'b0, raise_inc};
    assign prod       = $signed({mul_reg[41:0], 24'd0}) + $signed({25'd0, lo_reg});
    assign wsum       = $signed({{3{weight_reg[31]}}, weight_reg})
                      + $signed({inc_reg[33], inc_reg});
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        if (wsum[34:31] == 4'b0000 || wsum[34:31] == 4'b1111) begin
            wsat = wsum[31:0];
        end else if (wsum[34]) begin
            wsat = 32'h8000_0000;
        end else begin
            wsat = 32'h7FFF_FFFF;
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (clr_reg == FW'(FEATURES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_fire) begin
                    unique case (s_tuser)
                        KIND_SET: begin
                            if (!in_ok) state_next = S_FIN;
                            else if (in_val_clip == 17'd0) state_next = S_CL1;
                            else state_next = S_ST1;
                        end
                        KIND_CLEAR:    state_next = in_ok ? S_CL1 : S_FIN;
                        KIND_DECAY:    state_next = S_WK_A;
                        KIND_UPDATE:   state_next = S_UP1;
                        KIND_READ:     state_next = S_RD1;
                        KIND_CLEARALL: state_next = S_WK_A;
                        default:       state_next = S_FIN;
                    endcase
                end
            end
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_FIN;
            S_ST1:  state_next = S_ST2;
            S_ST2:  state_next = (t_rdata != 17'd0) ? S_FIN : S_SL;
            S_SL: begin
                if (cnt_reg < CW'(MAX_ACTIVE)) state_next = S_FIN;
                else if (min_reg >= MIN_TOP) state_next = S_FIN;
                else state_next = S_RS1;
            end
            S_RS1:  state_next = S_RS2;
            S_RS2:  state_next = S_WK_A;
            S_CL1:  state_next = S_CL2;
            S_CL2:  state_next = (t_rdata == 17'd0) ? S_FIN : S_CL3;
            S_CL3:  state_next = S_DROP;
            S_UP1:  state_next = S_UP2;
            S_UP2:  state_next = S_WK_A;
            S_WK_A: begin
                if (idx_reg == '0) begin
                    state_next = (op_reg == WOP_CULL) ? S_SL : S_FIN;
                end else begin
                    state_next = S_WK_B;
                end
            end
            S_WK_B: state_next = S_WK_C;
            S_WK_C: begin
                unique case (op_reg)
                    WOP_CLEARALL: state_next = S_DROP;
                    WOP_CULL:     state_next = drop_cull ? S_DROP : S_WK_A;
                    WOP_DECAY:    state_next = S_WK_D;
                    WOP_UPDATE:   state_next = S_WK_U1;
                    default:      state_next = S_WK_A;
                endcase
            end
            S_WK_D:  state_next = drop_decay ? S_DROP : S_WK_A;
            S_WK_U1: state_next = S_WK_U2;
            S_WK_U2: state_next = S_WK_U3;
            S_WK_U3: state_next = S_WK_A;
            S_DROP:  state_next = single_reg ? S_FIN : S_WK_A;
            S_FIN:   state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb begin
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        min_next     = min_reg;
        clr_next     = clr_reg;
        feat_next    = feat_reg;
        ok_next      = ok_reg;
        val_next     = val_reg;
        delta_next   = delta_reg;
        single_next  = single_reg;
        ent_next     = ent_reg;
        last_next    = last_reg;
        trace_next   = trace_reg;
        weight_next  = weight_reg;
        sd_next      = sd_reg;
        lo_next      = lo_reg;
        inc_next     = inc_reg;
        wout_next    = wout_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;

        mul_a = '0;
        mul_b = '0;

        t_we = 1'b0; t_waddr = ent_reg;  t_wdata = '0; t_raddr = feat_reg;
        w_we = 1'b0; w_waddr = ent_reg;  w_wdata = '0; w_raddr = feat_reg;
        l_we = 1'b0; l_waddr = PW'(idx_reg - 1'b1); l_wdata = last_reg;
        l_raddr = PW'(idx_reg - 1'b1);
        p_we = 1'b0; p_waddr = last_reg; p_wdata = PW'(idx_reg - 1'b1);
        p_raddr = feat_reg;

        unique case (state_reg)
            S_INIT: begin
                t_we = 1'b1; t_waddr = clr_reg; t_wdata = '0;
                w_we = 1'b1; w_waddr = clr_reg; w_wdata = '0;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE: begin
                if (s_fire) begin
                    feat_next   = FW'(s_tdata[11:0]);
                    ok_next     = in_ok;
                    val_next    = in_val_clip;
                    delta_next  = s_tdata[60:29];
                    single_next = 1'b0;
                    wout_next   = '0;
                    idx_next    = cnt_reg;
                    op_next     = (s_tuser == KIND_CLEARALL) ? WOP_CLEARALL : WOP_DECAY;
                end
            end
            S_RD2: begin
                wout_next = ok_reg ? w_rdata : 32'd0;
            end
            S_ST2: begin
                if (t_rdata != 17'd0) begin
                    t_we = 1'b1; t_waddr = feat_reg; t_wdata = val_reg;
                end
            end
            S_SL: begin
                if (cnt_reg < CW'(MAX_ACTIVE)) begin
                    t_we = 1'b1; t_waddr = feat_reg; t_wdata = val_reg;
                    l_we = 1'b1; l_waddr = PW'(cnt_reg); l_wdata = feat_reg;
                    p_we = 1'b1; p_waddr = feat_reg; p_wdata = PW'(cnt_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RS1: begin
                mul_a = $signed({17'd0, min_reg});
                mul_b = $signed(RECIP10);
            end
            S_RS2: begin
                min_next = raise_sum[16] ? MIN_TOP : raise_sum[15:0];
                idx_next = cnt_reg;
                op_next  = WOP_CULL;
            end
            S_CL2: begin
                idx_next    = CW'(p_rdata) + 1'b1;
                ent_next    = feat_reg;
                single_next = 1'b1;
                l_raddr     = PW'(cnt_reg - 1'b1);
            end
            S_CL3: begin
                last_next = l_rdata;
            end
            S_UP1: begin
                mul_a = $signed({delta_reg[31], delta_reg});
                mul_b = $signed({2'b00, step_reg});
            end
            S_UP2: begin
                sd_next  = mul_reg[47:0];
                idx_next = cnt_reg;
                op_next  = WOP_UPDATE;
            end
            S_WK_A: begin
                if (idx_reg == '0 && op_reg == WOP_CLEARALL) begin
                    min_next = min_start_reg;
                end
            end
            S_WK_B: begin
                ent_next = l_rdata;
                t_raddr  = l_rdata;
                w_raddr  = l_rdata;
                l_raddr  = PW'(cnt_reg - 1'b1);
            end
            S_WK_C: begin
                trace_next  = t_rdata;
                last_next   = l_rdata;
                weight_next = w_rdata;
                if (op_reg == WOP_DECAY) begin
                    mul_a = $signed({16'd0, t_rdata});
                    mul_b = $signed({1'b0, val_reg});
                end else if (op_reg == WOP_UPDATE) begin
                    mul_a = $signed({9'd0, sd_reg[23:0]});
                    mul_b = $signed({1'b0, t_rdata});
                end
                if (op_reg == WOP_CULL && !drop_cull) begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_WK_D: begin
                if (!drop_decay) begin
                    t_we = 1'b1; t_waddr = ent_reg; t_wdata = decay_new;
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_WK_U1: begin
                lo_next = mul_reg[40:0];
                mul_a   = $signed({{9{sd_reg[47]}}, sd_reg[47:24]});
                mul_b   = $signed({1'b0, trace_reg});
            end
            S_WK_U2: begin
                inc_next = prod[65:32];
            end
            S_WK_U3: begin
                w_we = 1'b1; w_waddr = ent_reg; w_wdata = wsat;
                idx_next = idx_reg - 1'b1;
            end
            S_DROP: begin
                // last entry moves into the freed slot
                t_we = 1'b1; t_waddr = ent_reg; t_wdata = '0;
                l_we = 1'b1;
                p_we = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (!single_reg) idx_next = idx_reg - 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, min_reg, 11'(cnt_reg), wout_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            op_reg        <= WOP_DECAY;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            min_reg       <= MIN_START_RST;
            clr_reg       <= '0;
            single_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            min_reg       <= min_next;
            clr_reg       <= clr_next;
            single_reg    <= single_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        feat_reg    <= feat_next;
        ok_reg      <= ok_next;
        val_reg     <= val_next;
        delta_reg   <= delta_next;
        ent_reg     <= ent_next;
        last_reg    <= last_next;
        trace_reg   <= trace_next;
        weight_reg  <= weight_next;
        sd_reg      <= sd_next;
        lo_reg      <= lo_next;
        inc_reg     <= inc_next;
        wout_reg    <= wout_next;
        m_tdata_reg <= m_tdata_next;
        mul_reg     <= mul_a * mul_b;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_SIZE_RST;
            min_start_reg <= MIN_START_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_STEP_SIZE:       step_reg      <= pwdata[15:0];
                REG_MIN_TRACE_START: min_start_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_STEP_SIZE:       prdata = {16'd0, step_reg};
            REG_MIN_TRACE_START: prdata = {16'd0, min_start_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------- memories ----------------
    sets_ram #(.WIDTH(17), .DEPTH(FEATURES)) u_trace_ram (
        .clk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    sets_ram #(.WIDTH(32), .DEPTH(FEATURES)) u_weight_ram (
        .clk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    sets_ram #(.WIDTH(FW), .DEPTH(MAX_ACTIVE)) u_list_ram (
        .clk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    sets_ram #(.WIDTH(PW), .DEPTH(FEATURES)) u_pos_ram (
        .clk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ACTIVE))
        else $error("active count above list depth");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + 1'b1
                            || cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("active count moved by more than one");

    a_walk_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WK_A) |-> (idx_reg <= cnt_reg))
        else $error("walk index beyond list end");

endmodule

// ===== design/sets_ram.sv =====
// ----------------------------------------------------------------------------
// sets_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sets_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
